FILE: rtl/accel_tilt_alignment_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the accelerometer tilt alignment block
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ALIGNMENT_MACROS_SVH
`define ACCEL_TILT_ALIGNMENT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define ATA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ATA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ATA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ATA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ata_pkg.sv
// ---------------------------------------------------------------------------
// ata_pkg
// Shared types and constants for the tilt alignment block.
// ---------------------------------------------------------------------------
package ata_pkg;
    localparam int CORDIC_ITERS    = 18;
    localparam int CORDIC_PRESHIFT = 14;
    localparam int SUM_W           = 26;
    localparam int CNT_W           = 10;
    localparam int CDW             = 36;
    localparam int ZW              = 26;
    localparam int ITW             = 5;
    localparam logic [CNT_W-1:0] TARGET_RESET = 10'd100;
    localparam logic signed [16:0] DEG90_Q88  = 17'sd23040;
    localparam logic signed [16:0] DEG180_Q88 = 17'sd46080;

    // Angle table, degrees in Q16
    function automatic logic signed [ZW-1:0] atan_q16(input logic [ITW-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 26'sd2949120;
            5'd1:  r = 26'sd1740967;
            5'd2:  r = 26'sd919879;
            5'd3:  r = 26'sd466945;
            5'd4:  r = 26'sd234379;
            5'd5:  r = 26'sd117265;
            5'd6:  r = 26'sd58666;
            5'd7:  r = 26'sd29335;
            5'd8:  r = 26'sd14668;
            5'd9:  r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Lane control bundle
    typedef struct packed {
        logic start;
    } lane_ctrl_t;
endpackage

FILE: rtl/ata_div_lane.sv
// ---------------------------------------------------------------------------
// ata_div_lane
// Restoring divider: signed sum over unsigned count, truncated to zero.
// ---------------------------------------------------------------------------
module ata_div_lane
    import ata_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctrl_t              ctrl,
    input  logic signed [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0]        count,
    output logic                    busy,
    output logic signed [15:0]      quot
);
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] q_reg, q_next;
    logic [SUM_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [ITW-1:0]   it_reg, it_next;
    logic             busy_reg, busy_next;
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] qs;

    // One quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[SUM_W-2:0], n_reg[SUM_W-1]};
        if (ctrl.start)
        begin
            neg_next  = sum[SUM_W-1];
            n_next    = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
            d_next    = count;
            rem_next  = '0;
            q_next    = '0;
            it_next   = ITW'(SUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[SUM_W-2:0], 1'b0};
            if (trial >= SUM_W'(d_reg))
            begin
                rem_next = trial - SUM_W'(d_reg);
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            if (it_reg == '0)
                busy_next = 1'b0;
            else
                it_next = it_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign qs   = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quot = qs[15:0];
    assign busy = busy_reg;
endmodule

FILE: rtl/ata_isqrt.sv
// ---------------------------------------------------------------------------
// ata_isqrt
// Digit recurrence integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module ata_isqrt
    import ata_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_ctrl_t  ctrl,
    input  logic [33:0] value,
    output logic        busy,
    output logic [16:0] root
);
    logic [33:0] v_reg, v_next;
    logic [33:0] r_reg, r_next;
    logic [33:0] b_reg, b_next;
    logic        busy_reg, busy_next;

    // Advance one bit pair per cycle
    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            v_next    = value;
            r_next    = '0;
            b_next    = 34'h1 << 32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= r_reg + b_reg)
            begin
                v_next = v_reg - (r_reg + b_reg);
                r_next = (r_reg >> 1) + b_reg;
            end
            else
                r_next = r_reg >> 1;
            b_next = b_reg >> 2;
            if (b_reg == 34'h1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign busy = busy_reg;
    assign root = r_reg[16:0];
endmodule

FILE: rtl/ata_cordic.sv
// ---------------------------------------------------------------------------
// ata_cordic
// Iterative vectoring CORDIC giving atan2 in Q8.8 degrees, clamped.
// ---------------------------------------------------------------------------
module ata_cordic
    import ata_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           ctrl,
    input  logic signed [17:0]   yin,
    input  logic signed [17:0]   xin,
    input  logic signed [16:0]   limit,
    output logic                 busy,
    output logic signed [16:0]   angle
);
    logic signed [CDW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [ITW-1:0]        it_reg, it_next;
    logic                  busy_reg, busy_next;
    logic                  zero_reg, zero_next;
    logic signed [CDW-1:0] xs, ys, xe, ye;
    logic signed [ZW-1:0]  zr;
    logic signed [16:0]    a;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        xe        = CDW'(xin) <<< CORDIC_PRESHIFT;
        ye        = CDW'(yin) <<< CORDIC_PRESHIFT;
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        // Load, rotating left half plane inputs by a quarter turn
        if (ctrl.start)
        begin
            zero_next = (xin == '0) && (yin == '0);
            it_next   = '0;
            busy_next = 1'b1;
            if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    x_next = ye;
                    y_next = -xe;
                    z_next = 26'sd5898240;
                end
                else
                begin
                    x_next = -ye;
                    y_next = xe;
                    z_next = -26'sd5898240;
                end
            end
            else
            begin
                x_next = xe;
                y_next = ye;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q16(it_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q16(it_reg);
            end
            if (it_reg == ITW'(CORDIC_ITERS - 1))
                busy_next = 1'b0;
            else
                it_next = it_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // Round to Q8.8 and clamp, giving zero for a zero input vector
    always_comb
    begin
        zr = (z_reg + 26'sd128) >>> 8;
        a  = zr[16:0];
        if (zero_reg)
            angle = '0;
        else if (a > limit)
            angle = limit;
        else if (a < -limit)
            angle = -limit;
        else
            angle = a;
    end

    assign busy = busy_reg;
endmodule

FILE: rtl/accel_tilt_alignment.sv
// ---------------------------------------------------------------------------
// accel_tilt_alignment
// Averages accelerometer samples and estimates magnitude, pitch and roll.
// ---------------------------------------------------------------------------
// One transaction at a time. An accumulating sample runs through the three
// divider lanes (26 quotient bits and a hand-off), the two square roots (each
// a set-up, 17 bit pairs and a hand-off) and the two CORDIC lanes run side by
// side (18 iterations and a hand-off), then loads the output register and
// goes back to idle, where the next sample is taken. Once the target count is
// reached a sample is taken in idle and the held results are repeated. While
// a result waits under a stall the input is stalled as well.
`include "accel_tilt_alignment_macros.svh"
module accel_tilt_alignment
    import ata_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mean_x,
    output logic signed [15:0] mean_y,
    output logic signed [15:0] mean_z,
    output logic [15:0]        mean_magnitude,
    output logic signed [15:0] pitch_deg,
    output logic signed [16:0] roll_deg,
    output logic [9:0]         samples_seen,
    output logic               done_res
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQ, S_SQRT, S_ANG, S_OUT} state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        target_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [15:0]      mx_reg, my_reg, mz_reg, pitch_reg;
    logic [15:0]             mag_reg;
    logic signed [16:0]      roll_reg;
    logic [33:0]             syz_reg, sall_reg;
    logic                    phase_reg;
    logic                    ov_reg;
    logic signed [15:0]      o_mx, o_my, o_mz, o_pitch;
    logic [15:0]             o_mag;
    logic signed [16:0]      o_roll;
    logic [CNT_W-1:0]        o_cnt;
    logic                    o_done;

    lane_ctrl_t div_ctl, sq_ctl, an_ctl;
    logic       bx, by, bz, bs, bp, br;
    logic signed [15:0] qx, qy, qz;
    logic [16:0]        rt;
    logic signed [16:0] pang, rang;
    logic [33:0]        sq_in;
    logic signed [SUM_W-1:0] sxn, syn, szn;
    logic               take;
    logic               load_out;

    assign take     = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign sxn = sx_reg + SUM_W'(accel_x);
    assign syn = sy_reg + SUM_W'(accel_y);
    assign szn = sz_reg + SUM_W'(accel_z);

    assign div_ctl.start = take && (cnt_reg < target_reg);
    assign sq_ctl.start  = (state_reg == S_SQ);
    assign an_ctl.start  = (state_reg == S_SQRT) && phase_reg && !bs && !sq_ctl.start;
    assign sq_in         = phase_reg ? sall_reg : syz_reg;

    // Output register loads on a repeated result or a finished one
    assign load_out = ((state_reg == S_IDLE) && take && !(cnt_reg < target_reg))
                   || ((state_reg == S_OUT) && (!ov_reg || !out_stall));

    // Divider lanes, one per axis
    ata_div_lane u_div_x (.clk, .rst_n, .ctrl(div_ctl), .sum(sxn),
                          .count(cnt_reg + 1'b1), .busy(bx), .quot(qx));
    ata_div_lane u_div_y (.clk, .rst_n, .ctrl(div_ctl), .sum(syn),
                          .count(cnt_reg + 1'b1), .busy(by), .quot(qy));
    ata_div_lane u_div_z (.clk, .rst_n, .ctrl(div_ctl), .sum(szn),
                          .count(cnt_reg + 1'b1), .busy(bz), .quot(qz));

    ata_isqrt u_sqrt (.clk, .rst_n, .ctrl(sq_ctl), .value(sq_in), .busy(bs), .root(rt));

    // Angle lanes
    ata_cordic u_pitch (.clk, .rst_n, .ctrl(an_ctl), .yin(18'(mx_reg)),
                        .xin(18'(syz_reg)), .limit(DEG90_Q88), .busy(bp), .angle(pang));
    ata_cordic u_roll (.clk, .rst_n, .ctrl(an_ctl), .yin(-18'(my_reg)),
                       .xin(18'(mz_reg)), .limit(DEG180_Q88), .busy(br), .angle(rang));

    // Sequence the lanes and hold results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            target_reg <= TARGET_RESET;
            sx_reg <= '0; sy_reg <= '0; sz_reg <= '0;
            cnt_reg <= '0;
            mx_reg <= '0; my_reg <= '0; mz_reg <= '0;
            mag_reg <= '0; pitch_reg <= '0; roll_reg <= '0;
            syz_reg <= '0; sall_reg <= '0; phase_reg <= 1'b0;
            ov_reg <= 1'b0;
            o_mx <= '0; o_my <= '0; o_mz <= '0; o_mag <= '0;
            o_pitch <= '0; o_roll <= '0; o_cnt <= '0; o_done <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                target_reg <= cfg_wdata;
            // Raise valid on a fresh load, drop it once the transaction leaves
            if (load_out)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (cnt_reg < target_reg)
                        begin
                            sx_reg  <= sxn; sy_reg <= syn; sz_reg <= szn;
                            cnt_reg <= cnt_reg + 1'b1;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            o_mx <= mx_reg; o_my <= my_reg; o_mz <= mz_reg;
                            o_mag <= mag_reg; o_pitch <= pitch_reg;
                            o_roll <= roll_reg; o_cnt <= cnt_reg;
                            o_done <= 1'b1;
                        end
                    end
                end
                S_DIV:
                begin
                    if (!bx && !by && !bz && !div_ctl.start)
                    begin
                        mx_reg <= qx; my_reg <= qy; mz_reg <= qz;
                        state_reg <= S_SQ;
                        syz_reg <= 34'(33'(qy * qy)) + 34'(33'(qz * qz));
                        phase_reg <= 1'b0;
                    end
                end
                S_SQ:
                begin
                    sall_reg  <= syz_reg + 34'(33'(mx_reg * mx_reg));
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (!bs)
                    begin
                        if (!phase_reg)
                        begin
                            syz_reg   <= 34'(rt);
                            phase_reg <= 1'b1;
                            state_reg <= S_SQ;
                        end
                        else
                        begin
                            mag_reg   <= rt[15:0];
                            state_reg <= S_ANG;
                        end
                    end
                end
                S_ANG:
                begin
                    if (!bp && !br)
                    begin
                        pitch_reg <= (mag_reg == '0) ? 16'sd0 : pang[15:0];
                        roll_reg  <= rang;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        o_mx <= mx_reg; o_my <= my_reg; o_mz <= mz_reg;
                        o_mag <= mag_reg; o_pitch <= pitch_reg;
                        o_roll <= roll_reg; o_cnt <= cnt_reg;
                        o_done <= (cnt_reg >= target_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = ov_reg;
    assign mean_x         = o_mx;
    assign mean_y         = o_my;
    assign mean_z         = o_mz;
    assign mean_magnitude = o_mag;
    assign pitch_deg      = o_pitch;
    assign roll_deg       = o_roll;
    assign samples_seen   = o_cnt;
    assign done_res       = o_done;

    `ATA_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !take)
    `ATA_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_reg == S_DIV, cnt_reg != '0)
    `ATA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
